### rtl/lsra_pkg.sv
// ----------------------------------------------------------------------------
// lsra_pkg: shared types and constants for the linear-scan register allocator
// Default parameter values, fixed field widths and the control records that
// travel along the cell chain and from the commit logic into the cells.
// ----------------------------------------------------------------------------
package lsra_pkg;

  localparam int unsigned MAX_REGISTERS_DEF = 32;
  localparam int unsigned POINT_WIDTH_DEF   = 16;
  localparam int unsigned ID_WIDTH_DEF      = 16;

  // register file as built, less the registers kept back for spill code
  localparam int unsigned BUILT_REGISTERS = 32;
  localparam int unsigned SPARE_REGISTERS = 3;

  localparam int unsigned CFG_W     = 6;
  localparam int unsigned REG_NUM_W = 5;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(BUILT_REGISTERS - SPARE_REGISTERS);

  // flags of the scan record handed from cell to cell
  typedef struct packed {
    logic tok;         // record belongs to the request under scan
    logic vic_found;   // an active slot has been seen
    logic free_found;  // a free slot below the limit has been seen
  } carry_flags_t;

  // slot write issued at commit
  typedef struct packed {
    logic en;
    logic set_valid;   // new allocation: slot becomes active
  } wr_ctrl_t;

endpackage

### rtl/lsra_cell.sv
// ----------------------------------------------------------------------------
// lsra_cell: one register slot of the allocator chain
// Holds the active flag, end point and id of the interval owning this
// register. When the scan record passes, it expires the slot and folds its
// own contribution (count, victim, lowest free) into the record.
// ----------------------------------------------------------------------------
module lsra_cell #(
  parameter int unsigned MAX_REGISTERS = 32,
  parameter int unsigned CELL_IDX      = 0,
  parameter int unsigned POINT_WIDTH   = 16,
  parameter int unsigned ID_WIDTH      = 16,
  localparam int unsigned IDX_W = (MAX_REGISTERS > 1) ? $clog2(MAX_REGISTERS) : 1,
  localparam int unsigned LIM_W = $clog2(MAX_REGISTERS + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // request under scan
  input  logic [POINT_WIDTH-1:0]   start_i,
  input  logic                     first_i,
  input  logic [LIM_W-1:0]         limit_i,
  // scan record from the left neighbor
  input  lsra_pkg::carry_flags_t   flags_i,
  input  logic [LIM_W-1:0]         count_i,
  input  logic [POINT_WIDTH-1:0]   vic_end_i,
  input  logic [ID_WIDTH-1:0]      vic_id_i,
  input  logic [IDX_W-1:0]         vic_idx_i,
  input  logic [IDX_W-1:0]         free_idx_i,
  // scan record to the right neighbor
  output lsra_pkg::carry_flags_t   flags_o,
  output logic [LIM_W-1:0]         count_o,
  output logic [POINT_WIDTH-1:0]   vic_end_o,
  output logic [ID_WIDTH-1:0]      vic_id_o,
  output logic [IDX_W-1:0]         vic_idx_o,
  output logic [IDX_W-1:0]         free_idx_o,
  // slot write
  input  lsra_pkg::wr_ctrl_t       wr_ctrl_i,
  input  logic [IDX_W-1:0]         wr_idx_i,
  input  logic [POINT_WIDTH-1:0]   wr_end_i,
  input  logic [ID_WIDTH-1:0]      wr_id_i
);
  import lsra_pkg::*;

  logic                   valid_q, valid_d;
  logic [POINT_WIDTH-1:0] end_q;
  logic [ID_WIDTH-1:0]    id_q;

  carry_flags_t           flags_q, flags_d;
  logic [LIM_W-1:0]       count_q, count_d;
  logic [POINT_WIDTH-1:0] vic_end_q, vic_end_d;
  logic [ID_WIDTH-1:0]    vic_id_q, vic_id_d;
  logic [IDX_W-1:0]       vic_idx_q, vic_idx_d;
  logic [IDX_W-1:0]       free_idx_q, free_idx_d;

  logic live, better, take_vic, take_free, wr_hit;

  // slot survives the clear flag and has not ended before the new start
  assign live   = valid_q && !first_i && !(end_q < start_i);
  assign better = !flags_i.vic_found || (end_q > vic_end_i) ||
                  ((end_q == vic_end_i) && (id_q > vic_id_i));
  assign take_vic  = live && better;
  assign take_free = !live && !flags_i.free_found && (LIM_W'(CELL_IDX) < limit_i);
  assign wr_hit    = wr_ctrl_i.en && (wr_idx_i == IDX_W'(CELL_IDX));

  always_comb begin
    valid_d    = valid_q;
    flags_d    = flags_q;
    count_d    = count_q;
    vic_end_d  = vic_end_q;
    vic_id_d   = vic_id_q;
    vic_idx_d  = vic_idx_q;
    free_idx_d = free_idx_q;
    flags_d.tok = flags_i.tok;
    if (flags_i.tok) begin
      valid_d            = live;
      flags_d.vic_found  = flags_i.vic_found || live;
      flags_d.free_found = flags_i.free_found || take_free;
      count_d            = live ? count_i + LIM_W'(1) : count_i;
      vic_end_d          = take_vic ? end_q : vic_end_i;
      vic_id_d           = take_vic ? id_q : vic_id_i;
      vic_idx_d          = take_vic ? IDX_W'(CELL_IDX) : vic_idx_i;
      free_idx_d         = take_free ? IDX_W'(CELL_IDX) : free_idx_i;
    end else if (wr_hit && wr_ctrl_i.set_valid) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      flags_q <= '0;
    end else begin
      valid_q <= valid_d;
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q    <= count_d;
    vic_end_q  <= vic_end_d;
    vic_id_q   <= vic_id_d;
    vic_idx_q  <= vic_idx_d;
    free_idx_q <= free_idx_d;
    if (wr_hit) begin
      end_q <= wr_end_i;
      id_q  <= wr_id_i;
    end
  end

  assign flags_o    = flags_q;
  assign count_o    = count_q;
  assign vic_end_o  = vic_end_q;
  assign vic_id_o   = vic_id_q;
  assign vic_idx_o  = vic_idx_q;
  assign free_idx_o = free_idx_q;

  // a write never lands while the scan record passes this slot
  a_no_wr_during_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_i.tok |-> !wr_ctrl_i.en)
    else $error("slot write during scan");

  // the record moves exactly one cell per cycle
  a_tok_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_i.tok |=> flags_o.tok)
    else $error("scan record lost");

  // the active count never drops while passing a cell
  a_count_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_i.tok |=> (count_o == $past(count_i)) || (count_o == $past(count_i) + LIM_W'(1)))
    else $error("scan count corrupted");

endmodule

### rtl/linear_scan_register_allocator_top.sv
// ----------------------------------------------------------------------------
// linear_scan_register_allocator_top: linear-scan register allocator
// Assigns a register to each live interval, spilling or evicting when full.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one interval request with
//   id, start, end and first_of_run. Requests must arrive sorted by start.
//   Output channel (out_valid_o/out_ready_i) returns one result per request:
//   got_register, assigned_reg, evicted_valid, evicted_id.
//   cfg_we_i/cfg_wdata_i write registers_in_use; write only while idle.
//   Each request walks a row of MAX_REGISTERS slot cells, one cell per
//   cycle, gathering expiry, active count, victim and lowest free slot.
//   The request is held in the item registers while it walks the cells, then the
//   commit step writes the output register; the next request is taken only
//   after that commit, so no new request is accepted while one is in flight.
//   A stalled receiver holds the commit step; the output register keeps the
//   previous result until taken while the next request scans.
//   Reset empties all slots and sets registers_in_use to 29.
// ----------------------------------------------------------------------------
module linear_scan_register_allocator_top #(
  parameter int unsigned MAX_REGISTERS = lsra_pkg::MAX_REGISTERS_DEF,
  parameter int unsigned POINT_WIDTH   = lsra_pkg::POINT_WIDTH_DEF,
  parameter int unsigned ID_WIDTH      = lsra_pkg::ID_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lsra_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [ID_WIDTH-1:0]            interval_id_i,
  input  logic [POINT_WIDTH-1:0]         interval_start_i,
  input  logic [POINT_WIDTH-1:0]         interval_end_i,
  input  logic                           first_of_run_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           got_register_o,
  output logic [lsra_pkg::REG_NUM_W-1:0] assigned_reg_o,
  output logic                           evicted_valid_o,
  output logic [ID_WIDTH-1:0]            evicted_id_o
);
  import lsra_pkg::*;

  localparam int unsigned IDX_W = (MAX_REGISTERS > 1) ? $clog2(MAX_REGISTERS) : 1;
  localparam int unsigned LIM_W = $clog2(MAX_REGISTERS + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0]             state_q, state_d;
  logic [CFG_W-1:0]       cfg_q;
  logic [LIM_W-1:0]       limit;
  logic                   head_tok_q;

  logic [ID_WIDTH-1:0]    item_id_q;
  logic [POINT_WIDTH-1:0] item_start_q, item_end_q;
  logic                   item_first_q;

  carry_flags_t           flags_c    [MAX_REGISTERS+1];
  logic [LIM_W-1:0]       count_c    [MAX_REGISTERS+1];
  logic [POINT_WIDTH-1:0] vic_end_c  [MAX_REGISTERS+1];
  logic [ID_WIDTH-1:0]    vic_id_c   [MAX_REGISTERS+1];
  logic [IDX_W-1:0]       vic_idx_c  [MAX_REGISTERS+1];
  logic [IDX_W-1:0]       free_idx_c [MAX_REGISTERS+1];

  wr_ctrl_t               wr_ctrl;
  logic [IDX_W-1:0]       wr_idx;
  logic                   accept, out_free, commit_fire, full, evict, alloc;

  logic                   out_valid_q;
  logic                   got_q, ev_valid_q;
  logic [REG_NUM_W-1:0]   reg_num_q;
  logic [ID_WIDTH-1:0]    ev_id_q;

  assign limit = (int'(cfg_q) > int'(MAX_REGISTERS)) ? LIM_W'(MAX_REGISTERS) : LIM_W'(cfg_q);

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign commit_fire = (state_q == ST_COMMIT) && out_free;

  // head of the chain: fresh scan record
  assign flags_c[0]    = '{tok: head_tok_q, vic_found: 1'b0, free_found: 1'b0};
  assign count_c[0]    = '0;
  assign vic_end_c[0]  = '0;
  assign vic_id_c[0]   = '0;
  assign vic_idx_c[0]  = '0;
  assign free_idx_c[0] = '0;

  for (genvar k = 0; k < MAX_REGISTERS; k++) begin : g_cell
    lsra_cell #(
      .MAX_REGISTERS(MAX_REGISTERS),
      .CELL_IDX     (k),
      .POINT_WIDTH  (POINT_WIDTH),
      .ID_WIDTH     (ID_WIDTH)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .start_i   (item_start_q),
      .first_i   (item_first_q),
      .limit_i   (limit),
      .flags_i   (flags_c[k]),
      .count_i   (count_c[k]),
      .vic_end_i (vic_end_c[k]),
      .vic_id_i  (vic_id_c[k]),
      .vic_idx_i (vic_idx_c[k]),
      .free_idx_i(free_idx_c[k]),
      .flags_o   (flags_c[k+1]),
      .count_o   (count_c[k+1]),
      .vic_end_o (vic_end_c[k+1]),
      .vic_id_o  (vic_id_c[k+1]),
      .vic_idx_o (vic_idx_c[k+1]),
      .free_idx_o(free_idx_c[k+1]),
      .wr_ctrl_i (wr_ctrl),
      .wr_idx_i  (wr_idx),
      .wr_end_i  (item_end_q),
      .wr_id_i   (item_id_q)
    );
  end

  // decision from the tail record, which holds once the scan has passed
  assign full  = (count_c[MAX_REGISTERS] >= limit);
  assign evict = (limit != '0) && full && flags_c[MAX_REGISTERS].vic_found &&
                 (vic_end_c[MAX_REGISTERS] > item_end_q);
  assign alloc = (limit != '0) && !full && flags_c[MAX_REGISTERS].free_found;

  assign wr_idx            = evict ? vic_idx_c[MAX_REGISTERS] : free_idx_c[MAX_REGISTERS];
  assign wr_ctrl.en        = commit_fire && (evict || alloc);
  assign wr_ctrl.set_valid = alloc;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (accept) state_d = ST_SCAN;
      ST_SCAN:   if (flags_c[MAX_REGISTERS].tok) state_d = ST_COMMIT;
      ST_COMMIT: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_q       <= CFG_RESET;
      head_tok_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_tok_q <= accept;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (commit_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_id_q    <= interval_id_i;
      item_start_q <= interval_start_i;
      item_end_q   <= interval_end_i;
      item_first_q <= first_of_run_i;
    end
    if (commit_fire) begin
      got_q      <= evict || alloc;
      reg_num_q  <= (evict || alloc) ? REG_NUM_W'(wr_idx) : '0;
      ev_valid_q <= evict;
      ev_id_q    <= evict ? vic_id_c[MAX_REGISTERS] : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign got_register_o  = got_q;
  assign assigned_reg_o  = reg_num_q;
  assign evicted_valid_o = ev_valid_q;
  assign evicted_id_o    = ev_id_q;

  a_tail_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_c[MAX_REGISTERS].tok |-> (state_q == ST_SCAN))
    else $error("scan record arrived outside scan");

  a_scan_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> flags_c[0].tok && (state_q == ST_SCAN))
    else $error("accepted request did not start a scan");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_c[MAX_REGISTERS].tok |-> (int'(count_c[MAX_REGISTERS]) <= int'(MAX_REGISTERS)))
    else $error("active count above slot count");

  a_evict_gets_reg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && evicted_valid_o |-> got_register_o)
    else $error("eviction without register");

endmodule

### verif/linear_scan_register_allocator_top_test.sv
// ----------------------------------------------------------------------------
// linear_scan_register_allocator_top_test: allocator self-checking bench
// Drives interval requests through a randomly idling valid/ready driver,
// predicts each allocation, eviction or spill with a scoreboard model of the
// active set, and checks every result field by field as it is taken.
// ----------------------------------------------------------------------------
module linear_scan_register_allocator_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_REGS  = lsra_pkg::MAX_REGISTERS_DEF;
  localparam int unsigned PW        = lsra_pkg::POINT_WIDTH_DEF;
  localparam int unsigned IW        = lsra_pkg::ID_WIDTH_DEF;
  localparam int unsigned CW        = lsra_pkg::CFG_W;
  localparam int unsigned NUM_W     = lsra_pkg::REG_NUM_W;
  localparam int unsigned MAX_POINT = (1 << PW) - 1;
  localparam int unsigned MAX_ID    = (1 << IW) - 1;

  typedef struct {
    logic [IW-1:0] id;
    logic [PW-1:0] start_pt;
    logic [PW-1:0] end_pt;
    logic          first;
    int unsigned   gap;
  } interval_req_t;

  typedef struct packed {
    logic             got;
    logic [NUM_W-1:0] num;
    logic             ev;
    logic [IW-1:0]    ev_id;
  } alloc_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [CW-1:0]    cfg_wdata_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [IW-1:0]    interval_id_i = '0;
  logic [PW-1:0]    interval_start_i = '0;
  logic [PW-1:0]    interval_end_i = '0;
  logic             first_of_run_i = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic             got_register_o;
  logic [NUM_W-1:0] assigned_reg_o;
  logic             evicted_valid_o;
  logic [IW-1:0]    evicted_id_o;

  linear_scan_register_allocator_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .interval_id_i    (interval_id_i),
    .interval_start_i (interval_start_i),
    .interval_end_i   (interval_end_i),
    .first_of_run_i   (first_of_run_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .got_register_o   (got_register_o),
    .assigned_reg_o   (assigned_reg_o),
    .evicted_valid_o  (evicted_valid_o),
    .evicted_id_o     (evicted_id_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // scoreboard copy of the active set; a free register is one not live
  logic [MAX_REGS-1:0] live = '0;
  logic [PW-1:0]       live_end[MAX_REGS];
  logic [IW-1:0]       live_id[MAX_REGS];
  logic [CW-1:0]       regs_cfg = lsra_pkg::CFG_RESET;

  interval_req_t pending[$];
  alloc_t        expected[$];
  int unsigned   n_offered = 0;
  int unsigned   n_taken = 0;
  int unsigned   n_results = 0;
  int unsigned   n_bad = 0;
  bit            quiet = 1'b0;
  bit            rx_hold = 1'b0;
  logic [PW-1:0] run_start = '0;
  logic [IW-1:0] run_id = '0;

  function automatic alloc_t allocate(input logic [IW-1:0] id, input logic [PW-1:0] st,
                                      input logic [PW-1:0] en, input logic first);
    alloc_t      r;
    int unsigned lim;
    int unsigned active;
    int          vic;
    bit          vic_ok;
    r = '0;
    lim = (regs_cfg > MAX_REGS) ? MAX_REGS : regs_cfg;
    if (first) begin
      live = '0;
    end
    active = 0;
    for (int i = 0; i < MAX_REGS; i++) begin
      if (live[i] && live_end[i] < st) begin
        live[i] = 1'b0;
      end
      if (live[i]) begin
        active++;
      end
    end
    if (lim == 0) begin
      // nothing allocatable, spill
    end else if (active >= lim) begin
      vic = 0;
      vic_ok = 1'b0;
      for (int i = 0; i < MAX_REGS; i++) begin
        if (live[i] && (!vic_ok || live_end[i] > live_end[vic] ||
            (live_end[i] == live_end[vic] && live_id[i] > live_id[vic]))) begin
          vic = i;
          vic_ok = 1'b1;
        end
      end
      if (vic_ok && live_end[vic] > en) begin
        r.got = 1'b1;
        r.num = NUM_W'(vic);
        r.ev = 1'b1;
        r.ev_id = live_id[vic];
        live_end[vic] = en;
        live_id[vic] = id;
      end
    end else begin
      for (int i = 0; i < lim; i++) begin
        if (!live[i]) begin
          r.got = 1'b1;
          r.num = NUM_W'(i);
          live[i] = 1'b1;
          live_end[i] = en;
          live_id[i] = id;
          break;
        end
      end
    end
    return r;
  endfunction

  // monitor: predict on request accept, check on result accept
  always @(posedge clk_i) begin : monitor
    alloc_t seen;
    alloc_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        seen = '{got_register_o, assigned_reg_o, evicted_valid_o, evicted_id_o};
        n_results++;
        if (expected.size() == 0) begin
          if (n_bad < 10) begin
            $display("result %0d unexpected: got=%0b reg=%0d ev=%0b ev_id=%h",
                     n_results, seen.got, seen.num, seen.ev, seen.ev_id);
          end
          n_bad++;
        end else begin
          want = expected.pop_front();
          if (seen.got !== want.got || seen.num !== want.num ||
              seen.ev !== want.ev || seen.ev_id !== want.ev_id) begin
            if (n_bad < 10) begin
              $display("result %0d mismatch: expected got=%0b reg=%0d ev=%0b ev_id=%h, %s",
                       n_results, want.got, want.num, want.ev, want.ev_id,
                       $sformatf("actual got=%0b reg=%0d ev=%0b ev_id=%h",
                                 seen.got, seen.num, seen.ev, seen.ev_id));
            end
            n_bad++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        expected.push_back(allocate(interval_id_i, interval_start_i, interval_end_i,
                                    first_of_run_i));
        n_taken++;
      end
    end
  end

  // driver: each request waits its own gap, then holds valid until taken
  int unsigned   idle_left = 0;
  bit            gap_served = 1'b0;
  interval_req_t nxt;

  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && n_taken != n_offered)) begin
      if (idle_left != 0) begin
        in_valid_i <= 1'b0;
        idle_left--;
      end else if (pending.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (pending[0].gap != 0 && !gap_served) begin
        in_valid_i <= 1'b0;
        idle_left = pending[0].gap - 1;
        gap_served = 1'b1;
      end else begin
        nxt = pending.pop_front();
        interval_id_i <= nxt.id;
        interval_start_i <= nxt.start_pt;
        interval_end_i <= nxt.end_pt;
        first_of_run_i <= nxt.first;
        in_valid_i <= 1'b1;
        n_offered++;
        gap_served = 1'b0;
      end
    end
  end

  // receiver: random stall before each result, plus the long hold
  int unsigned rx_seen = 0;
  int unsigned rx_wait = 0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (n_results != rx_seen) begin
        rx_seen = n_results;
        rx_wait = quiet ? 0 : $urandom_range(0, 11);
      end
      out_ready_i <= !rx_hold && rx_wait == 0;
      if (rx_wait != 0) begin
        rx_wait--;
      end
    end
  end

  function automatic logic [PW-1:0] sat_point(input int unsigned v);
    return (v > MAX_POINT) ? PW'(MAX_POINT) : PW'(v);
  endfunction

  task automatic push_request(input logic [IW-1:0] id, input logic [PW-1:0] st,
                              input logic [PW-1:0] en, input logic first);
    interval_req_t r;
    r.id = id;
    r.start_pt = st;
    r.end_pt = en;
    r.first = first;
    r.gap = quiet ? 0 : $urandom_range(0, 11);
    pending.push_back(r);
  endtask

  // sorted run of overlapping intervals; reach bounds interval length
  task automatic add_run(input int unsigned n, input bit fresh, input int unsigned reach);
    if (fresh) begin
      run_start = ($urandom_range(0, 3) == 0) ? PW'($urandom_range(60000, MAX_POINT))
                                              : PW'($urandom_range(0, MAX_POINT));
      run_id = IW'($urandom_range(0, MAX_ID));
    end
    for (int k = 0; k < n; k++) begin
      run_start = sat_point(run_start + $urandom_range(0, 3));
      run_id = run_id + IW'($urandom_range(1, 2));
      push_request(run_id, run_start, sat_point(run_start + $urandom_range(0, reach)),
                   fresh && k == 0);
    end
  endtask

  task automatic settle();
    while (pending.size() != 0 || in_valid_i || n_taken != n_offered ||
           expected.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_regs(input logic [CW-1:0] v);
    settle();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    regs_cfg = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int unsigned phase_cfg[12];
    int unsigned reach_pick[4];
    int unsigned added;
    int unsigned target;
    int unsigned n;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset count of 29, extremes, inverted and unsorted intervals
    push_request(IW'(0), PW'(0), PW'(0), 1'b1);
    push_request(IW'(MAX_ID), PW'(0), PW'(MAX_POINT), 1'b0);
    push_request(IW'(1), PW'(0), PW'(MAX_POINT), 1'b0);
    push_request(IW'(2), PW'(5), PW'(3), 1'b0);
    push_request(IW'(3), PW'(2), PW'(10), 1'b0);
    push_request(IW'(16'h8000), PW'(MAX_POINT), PW'(MAX_POINT), 1'b0);
    // single register: evict, tie on end spills, evict again
    write_regs(CW'(1));
    push_request(IW'(10), PW'(0), PW'(100), 1'b1);
    push_request(IW'(11), PW'(1), PW'(50), 1'b0);
    push_request(IW'(12), PW'(2), PW'(50), 1'b0);
    push_request(IW'(13), PW'(3), PW'(40), 1'b0);
    // no registers at all
    write_regs(CW'(0));
    push_request(IW'(20), PW'(0), PW'(5), 1'b1);
    push_request(IW'(21), PW'(1), PW'(6), 1'b0);
    // count above the built size is clamped
    write_regs(CW'(63));
    push_request(IW'(30), PW'(0), PW'(1000), 1'b1);
    push_request(IW'(31), PW'(0), PW'(1000), 1'b0);
    push_request(IW'(32), PW'(0), PW'(900), 1'b0);
    // count lowered with three still active
    write_regs(CW'(2));
    push_request(IW'(33), PW'(1), PW'(950), 1'b0);
    push_request(IW'(34), PW'(1), PW'(2000), 1'b0);

    phase_cfg = '{32, 63, 2, 29, 1, 16, 0, 4, $urandom_range(33, 62),
                  $urandom_range(1, 31), 8, $urandom_range(0, 63)};
    reach_pick = '{4, 40, 300, 5000};
    foreach (phase_cfg[p]) begin
      write_regs(CW'(phase_cfg[p]));
      quiet = (p == 3 || p == 8);
      target = (phase_cfg[p] == 0) ? 20 : 78;
      added = 0;
      while (added < target) begin
        if ($urandom_range(0, 9) == 0) begin
          // broken ordering and inverted intervals
          n = $urandom_range(1, 3);
          repeat (n) begin
            push_request(IW'($urandom_range(0, MAX_ID)), PW'($urandom_range(0, MAX_POINT)),
                         PW'($urandom_range(0, MAX_POINT)), $urandom_range(0, 7) == 0);
          end
        end else begin
          n = $urandom_range(8, 60);
          // first run of a phase may continue the previous active set
          add_run(n, !(added == 0 && $urandom_range(0, 1) == 0),
                  reach_pick[$urandom_range(0, 3)]);
        end
        added += n;
      end
      // sender pauses here until every result is back
      settle();
    end
    quiet = 1'b0;

    settle();
    repeat (40) @(posedge clk_i);
    if (n_bad == 0 && expected.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // long receiver hold so the block backs up and stalls its input
  initial begin
    while (n_taken < 250) begin
      @(posedge clk_i);
    end
    rx_hold = 1'b1;
    repeat (500) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
